>>> rtl/qsl_pkg.sv
// Shared constants for the quicksort block.
package qsl_pkg;

  localparam int DATA_W       = 32;
  localparam int DEF_CAPACITY = 64;

endpackage : qsl_pkg

>>> rtl/quicksort_lomuto.sv
// Top level of the quicksort block: loader, partition sequencer and result streamer.
//
//   Channel | Direction | Beat contents                          | Accepted when
//   --------+-----------+----------------------------------------+---------------------------
//   in_     | slave     | tdata = value, tlast = last            | in_tvalid && in_tready
//   out_    | master    | tdata = sorted_value, tlast = final_res,| out_tvalid && out_tready
//           |           | tuser = truncated                      |
//
// Loading accepts one beat per cycle. Once the beat marked last is taken the block
// sorts in place; with the single read port of the element store, each element of the
// range is read (S_RD_J) and then compared (S_CMP), and each exchange writes its two
// entries in turn (S_SW1, S_SW2); each range adds a stack pop, pivot fetch and pushes.
// Each result then passes S_OUT_RD, S_OUT_LD and S_OUT_WAIT, where it waits out any stall.
// Reset (synchronous, active low) empties the store and clears the stack pointer
// and the overflow flag; no clearing pass is needed since only loaded entries are read.
// While sorting or streaming results, in_tready is low.
module quicksort_lomuto
  import qsl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input beats.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] value (signed)
  input  logic              in_tlast,   // last
  // Result beats.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] sorted_value (signed)
  output logic              out_tlast,  // final_res
  output logic              out_tuser   // [0] truncated
);

  // Index width into the store, and a count width that can hold CAPACITY itself.
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam int SW = 2 * IW;  // stack entry: high index above low index

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_POP, S_POP_WAIT, S_PIV, S_RD_J, S_CMP, S_SW1, S_SW2,
    S_FIN1, S_FIN2, S_PUSH1, S_PUSH2, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     sp_r, sp_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IW-1:0]     lo_r, lo_nxt;
  logic [IW-1:0]     hi_r, hi_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [IW-1:0]     place_r, place_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [DATA_W-1:0] pivot_r, pivot_nxt;
  logic [DATA_W-1:0] aj_r, aj_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_user_r, out_user_nxt;

  // Element store ports.
  logic              st_we;
  logic [IW-1:0]     st_waddr;
  logic [DATA_W-1:0] st_wdata;
  logic [IW-1:0]     st_raddr;
  logic [DATA_W-1:0] st_rdata;

  // Range stack ports.
  logic              rs_we;
  logic [IW-1:0]     rs_waddr;
  logic [SW-1:0]     rs_wdata;
  logic [IW-1:0]     rs_raddr;
  logic [SW-1:0]     rs_rdata;

  logic [CW-1:0]     sp_m1;
  logic              less;
  logic              store_room;
  logic              stack_room;

  qsl_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qsl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stack (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  assign sp_m1      = sp_r - CW'(1);
  // The one comparator of the datapath: signed order of a store word against the pivot.
  assign less       = $signed(st_rdata) < $signed(pivot_r);
  assign store_room = fill_r < CW'(CAPACITY);
  assign stack_room = sp_r < CW'(CAPACITY);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    sp_nxt        = sp_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    place_nxt     = place_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    aj_nxt        = aj_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    st_we    = 1'b0;
    st_waddr = fill_r[IW-1:0];
    st_wdata = in_tdata;
    st_raddr = j_r;
    rs_we    = 1'b0;
    rs_waddr = sp_r[IW-1:0];
    rs_wdata = {hi_r, lo_r};
    rs_raddr = sp_m1[IW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          // A beat that finds the store full is dropped, but the run is marked.
          if (store_room) begin
            st_we    = 1'b1;
            fill_nxt = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        k_nxt = '0;
        if (fill_r < CW'(2)) begin
          state_nxt = S_OUT_RD;
        end else begin
          rs_we     = 1'b1;
          rs_waddr  = '0;
          rs_wdata  = {IW'(fill_r - CW'(1)), {IW{1'b0}}};
          sp_nxt    = CW'(1);
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        lo_nxt   = rs_rdata[IW-1:0];
        hi_nxt   = rs_rdata[SW-1:IW];
        st_raddr = rs_rdata[SW-1:IW];
        if (rs_rdata[IW-1:0] >= rs_rdata[SW-1:IW]) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_PIV;
        end
      end

      S_PIV: begin
        pivot_nxt = st_rdata;
        place_nxt = lo_r;
        j_nxt     = lo_r;
        state_nxt = S_RD_J;
      end

      S_RD_J: begin
        if (j_r == hi_r) begin
          // Scan done: the pivot goes to its final place.
          st_raddr = place_r;
          if (place_r == hi_r) begin
            state_nxt = S_PUSH1;
          end else begin
            state_nxt = S_FIN1;
          end
        end else begin
          st_raddr  = j_r;
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        st_raddr = place_r;
        if (less) begin
          if (place_r == j_r) begin
            place_nxt = place_r + IW'(1);
            j_nxt     = j_r + IW'(1);
            state_nxt = S_RD_J;
          end else begin
            aj_nxt    = st_rdata;
            state_nxt = S_SW1;
          end
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_RD_J;
        end
      end

      S_SW1: begin
        st_we     = 1'b1;
        st_waddr  = j_r;
        st_wdata  = st_rdata;
        state_nxt = S_SW2;
      end

      S_SW2: begin
        st_we     = 1'b1;
        st_waddr  = place_r;
        st_wdata  = aj_r;
        place_nxt = place_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        state_nxt = S_RD_J;
      end

      S_FIN1: begin
        st_we     = 1'b1;
        st_waddr  = hi_r;
        st_wdata  = st_rdata;
        state_nxt = S_FIN2;
      end

      S_FIN2: begin
        st_we     = 1'b1;
        st_waddr  = place_r;
        st_wdata  = pivot_r;
        state_nxt = S_PUSH1;
      end

      S_PUSH1: begin
        // Left part, only if it holds two or more elements.
        if (({1'b0, place_r} > ({1'b0, lo_r} + CW'(1))) && stack_room) begin
          rs_we    = 1'b1;
          rs_wdata = {place_r - IW'(1), lo_r};
          sp_nxt   = sp_r + CW'(1);
        end
        state_nxt = S_PUSH2;
      end

      S_PUSH2: begin
        if ((({1'b0, place_r} + CW'(1)) < {1'b0, hi_r}) && stack_room) begin
          rs_we    = 1'b1;
          rs_wdata = {hi_r, place_r + IW'(1)};
          sp_nxt   = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end

      S_OUT_RD: begin
        st_raddr  = k_r;
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = st_rdata;
        out_last_nxt  = ({1'b0, k_r} + CW'(1)) == fill_r;
        out_user_nxt  = ovf_r;
        state_nxt     = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            sp_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    place_r    <= place_nxt;
    k_r        <= k_nxt;
    pivot_r    <= pivot_nxt;
    aj_r       <= aj_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // A result is only ever offered from the waiting state.
  a_valid_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT_WAIT))
    else $error("result offered outside the output wait state");

  // Loading and streaming never overlap.
  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

  // The fill count never passes the capacity.
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // Handing over the final result empties the block for the next set.
  a_run_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && fill_r == '0 && !ovf_r))
    else $error("block not emptied after the final result");

  // Pending ranges never exceed the stack depth.
  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(CAPACITY))
    else $error("range stack pointer beyond depth");

endmodule : quicksort_lomuto

>>> rtl/qsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : qsl_ram

>>> tb/tb_quicksort_lomuto.sv
// Self-checking testbench for the quicksort block: random and directed sets against a local sort.
`timescale 1ns / 100ps

module tb_quicksort_lomuto;
  import qsl_pkg::*;

  // The block is built at its default capacity; the local copy of the store matches it.
  localparam int CAP           = DEF_CAPACITY;
  // A full set can drive the partition loop to its quadratic worst case, with an exchange at
  // every step and no beat moving on either side, and the limit leaves a wide margin above
  // that worst case.
  localparam int QUIET_LIMIT   = 40000;
  // Cycles to keep watching the result side once everything expected has arrived.
  localparam int SETTLE_CYCLES = 40;
  // Random items per idling phase, not counting the large set.
  localparam int PHASE_ITEMS   = 10;

  // Shapes of the content of a generated set.
  typedef enum int {
    STY_WIDE,
    STY_NARROW,
    STY_EDGE,
    STY_RISING,
    STY_FALLING,
    STY_FLAT
  } set_style_t;

  // One input beat as it waits in the queue of pending beats.
  typedef struct {
    logic [DATA_W-1:0] value;
    logic              last;
  } load_beat_t;

  // One result beat as it is predicted.
  typedef struct {
    logic [DATA_W-1:0] value;
    logic              final_res;
    logic              truncated;
  } sorted_beat_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // [31:0] value (signed)
  logic              in_tlast   = 1'b0; // last
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;         // [31:0] sorted_value (signed)
  logic              out_tlast;         // final_res
  logic              out_tuser;         // [0] truncated

  quicksort_lomuto #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------------------------
  // Local sorter. It keeps its own copy of the element store, the fill level and the overflow
  // flag, and on the beat marked last sorts the set with the same Lomuto scheme: the last entry
  // of a range is the pivot and only strictly smaller entries move to its left. Pending ranges
  // live on an explicit stack, so the order of exchanges is the block's own.
  // ---------------------------------------------------------------------------------------------
  logic [DATA_W-1:0] set_mem [CAP];
  int                set_fill    = 0;
  bit                set_dropped = 1'b0;
  sorted_beat_t      sorted_expect [$];

  function automatic void swap_entries(int a, int b);
    logic [DATA_W-1:0] t;
    t          = set_mem[a];
    set_mem[a] = set_mem[b];
    set_mem[b] = t;
  endfunction

  // Partitions lo..hi around set_mem[hi] and returns where the pivot ends up.
  function automatic int lomuto_split(int lo, int hi);
    logic [DATA_W-1:0] pivot;
    int                place;
    pivot = set_mem[hi];
    place = lo;
    for (int j = lo; j < hi; j++) begin
      if ($signed(set_mem[j]) < $signed(pivot)) begin
        swap_entries(place, j);
        place++;
      end
    end
    swap_entries(place, hi);
    return place;
  endfunction

  function automatic void sort_set(int count);
    int lo_stk [CAP];
    int hi_stk [CAP];
    int sp;
    int lo;
    int hi;
    int p;
    sp = 0;
    if (count < 2) return;
    lo_stk[0] = 0;
    hi_stk[0] = count - 1;
    sp        = 1;
    while (sp > 0) begin
      sp--;
      lo = lo_stk[sp];
      hi = hi_stk[sp];
      if (lo >= hi) continue;
      p = lomuto_split(lo, hi);
      // Ranges of fewer than two entries are never pushed; the lower part goes first so
      // that the upper part is popped next, as in the block.
      if (lo < p - 1 && sp < CAP) begin
        lo_stk[sp] = lo;
        hi_stk[sp] = p - 1;
        sp++;
      end
      if (p + 1 < hi && sp < CAP) begin
        lo_stk[sp] = p + 1;
        hi_stk[sp] = hi;
        sp++;
      end
    end
  endfunction

  // Called for every input beat that the block takes.
  function automatic void predict_beat(logic [DATA_W-1:0] v, logic last);
    sorted_beat_t r;
    if (set_fill < CAP) begin
      set_mem[set_fill] = v;
      set_fill++;
    end else begin
      // Store full: the beat is dropped and the whole run will carry the truncated flag.
      set_dropped = 1'b1;
    end
    if (!last) return;
    sort_set(set_fill);
    for (int k = 0; k < set_fill; k++) begin
      r.value     = set_mem[k];
      r.final_res = (k == set_fill - 1);
      r.truncated = set_dropped;
      sorted_expect.push_back(r);
    end
    set_fill    = 0;
    set_dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Idling control. The sequencer sets the chance of a sender gap and of a receiver stall per
  // phase; now and then a calm stretch suspends both, so that long runs of back-to-back beats
  // also occur inside the idling phases.
  // ---------------------------------------------------------------------------------------------
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int calm_left          = 0;

  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(63) == 0) begin
      calm_left <= $urandom_range(40, 10);
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Driver. Beats come from the pending queue. A beat on the bus is held until it is taken;
  // only then may the next one be presented or a gap inserted. The prediction for a taken beat
  // uses the values that were on the bus before this edge.
  // ---------------------------------------------------------------------------------------------
  load_beat_t pending_beats [$];
  load_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_beat(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 &&
            (calm_left != 0 || $urandom_range(99) >= sender_idle_pct)) begin
          next_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.value;
          in_tlast  <= next_beat.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor. Every result beat taken is checked against the oldest prediction, field by field.
  // A beat with nothing predicted counts as a failure too; checking carries on regardless.
  // ---------------------------------------------------------------------------------------------
  sorted_beat_t head_expect;
  int           mismatch_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_expect.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d", $signed(out_tdata));
          mismatch_count++;
        end else begin
          head_expect = sorted_expect.pop_front();
          if (out_tdata !== head_expect.value) begin
            $error("sorted_value: expected %0d, got %0d",
                   $signed(head_expect.value), $signed(out_tdata));
            mismatch_count++;
          end
          if (out_tlast !== head_expect.final_res) begin
            $error("final_res: expected %0b, got %0b", head_expect.final_res, out_tlast);
            mismatch_count++;
          end
          if (out_tuser !== head_expect.truncated) begin
            $error("truncated: expected %0b, got %0b", head_expect.truncated, out_tuser);
            mismatch_count++;
          end
        end
      end
      out_tready <= (calm_left != 0) || ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: too long without any beat moving on either side ends the run as a failure.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus. The sequencer works on falling edges so that it never races the clocked blocks.
  // ---------------------------------------------------------------------------------------------
  task automatic push_beat(logic [DATA_W-1:0] v, logic last);
    load_beat_t b;
    b.value = v;
    b.last  = last;
    pending_beats.push_back(b);
  endtask

  // Queues one set of n beats, the n-th marked last.
  task automatic queue_set(int n, set_style_t style);
    int                base;
    logic [DATA_W-1:0] v;
    base = int'($urandom_range(2000)) - 1000;
    for (int k = 0; k < n; k++) begin
      case (style)
        STY_WIDE:    v = $urandom;
        STY_NARROW:  v = int'($urandom_range(16)) - 8;
        STY_EDGE: begin
          case ($urandom_range(3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            default: v = 32'hffff_ffff;
          endcase
        end
        STY_RISING:  v = base + k;
        STY_FALLING: v = base - k;
        default:     v = base;
      endcase
      push_beat(v, k == n - 1);
    end
  endtask

  // Waits until every beat has been taken and every predicted result has come back.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || sorted_expect.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int loaded;
    int n;

    while (!rst_n) @(negedge clk);

    // Directed sets, with no idling.
    // A set of a single element, the largest value.
    push_beat(32'h7fff_ffff, 1'b1);
    // Both extremes, zero and the values either side of it.
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'h7fff_ffff, 1'b0);
    push_beat(32'h0000_0000, 1'b0);
    push_beat(32'hffff_ffff, 1'b0);
    push_beat(32'h0000_0001, 1'b1);
    // All entries equal: nothing is strictly below the pivot.
    push_beat(-32'sd5, 1'b0);
    push_beat(-32'sd5, 1'b0);
    push_beat(-32'sd5, 1'b1);
    // Already in order, then in reverse order.
    push_beat(32'd1, 1'b0);
    push_beat(32'd2, 1'b0);
    push_beat(32'd3, 1'b0);
    push_beat(32'd4, 1'b1);
    push_beat(32'd4, 1'b0);
    push_beat(32'd3, 1'b0);
    push_beat(32'd2, 1'b0);
    push_beat(32'd1, 1'b1);
    // Smallest value twice, and a pair that needs a swap.
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'h8000_0000, 1'b1);
    push_beat(32'd1, 1'b0);
    push_beat(32'd0, 1'b1);
    wait_drained();

    // Random sets over four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 45;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 45;
        end
        default: begin
          sender_idle_pct    = 25;
          receiver_stall_pct = 25;
        end
      endcase
      // A set past capacity fills the store in rising order, the deepest partition, and
      // drops its tail, the beat marked last among them, so the whole run is flagged.
      if (phase == 3) queue_set(CAP + 3, STY_RISING);
      loaded = 0;
      while (loaded < PHASE_ITEMS) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        queue_set(n, set_style_t'($urandom_range(5)));
        loaded += n;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : tb_quicksort_lomuto

>>> files.f
rtl/qsl_pkg.sv
rtl/qsl_ram.sv
rtl/quicksort_lomuto.sv
tb/tb_quicksort_lomuto.sv
